// ===== rtl/core/ppmh_pkg.sv =====
// Shared types and constants for the binary PPM header parser.
package ppmh_pkg;

  // Parser phases; each header field has a skip, a comment and a token phase
  typedef enum logic [3:0] {
    PH_MAG0   = 4'd0,
    PH_MAG1   = 4'd1,
    PH_SKIP_W = 4'd2,
    PH_COMM_W = 4'd3,
    PH_TOK_W  = 4'd4,
    PH_SKIP_H = 4'd5,
    PH_COMM_H = 4'd6,
    PH_TOK_H  = 4'd7,
    PH_SKIP_M = 4'd8,
    PH_COMM_M = 4'd9,
    PH_TOK_M  = 4'd10,
    PH_PIX    = 4'd11,
    PH_ERR    = 4'd12
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrNotP6     = 3'd1;
  localparam logic [2:0] ErrEarlyEnd  = 3'd2;
  localparam logic [2:0] ErrOpenComm  = 3'd3;
  localparam logic [2:0] ErrBadDims   = 3'd4;

  // Character codes
  localparam logic [7:0] CharP       = 8'h50;
  localparam logic [7:0] CharSix     = 8'h36;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;

  // Limits
  localparam int unsigned AccWidth = 24;
  localparam int unsigned CntWidth = 34;
  localparam logic [AccWidth-1:0] AccMax    = 24'hFFFFFF;
  localparam logic [AccWidth-1:0] MaxDim    = 24'd65535;
  localparam logic [AccWidth-1:0] MaxSample = 24'd255;

  // One parser result
  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [15:0]        image_width;
    logic [15:0]        image_height;
    logic signed [24:0] max_value;
    logic [2:0]         error_code;
    logic [7:0]         pixel_value;
    logic               final_pixel;
    logic               size_mismatch;
  } result_t;

endpackage

// ===== rtl/core/ppmh_core.sv =====
// Parser state registers and the per-byte step logic.
module ppmh_core #(
  parameter logic [ppmh_pkg::AccWidth-1:0] MaxDim = ppmh_pkg::MaxDim
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  logic [7:0]       data_i,
  input  logic             eof_i,
  output ppmh_pkg::result_t result_o
);

  ppmh_pkg::phase_e phase_q, phase_d;
  logic                              first_ok_q, first_ok_d;
  logic                              sign_q, sign_d;
  logic                              ended_q, ended_d;
  logic [ppmh_pkg::AccWidth-1:0]     acc_q, acc_d;
  logic [15:0]                       width_q, width_d;
  logic [15:0]                       height_q, height_d;
  logic [31:0]                       prod_q;
  logic [ppmh_pkg::CntWidth-1:0]     expected_q, expected_d;
  logic [ppmh_pkg::CntWidth-1:0]     seen_q, seen_d;

  logic                              is_ws;
  logic                              is_digit;
  logic [ppmh_pkg::AccWidth-1:0]     digit;
  logic [27:0]                       acc_next;
  logic [ppmh_pkg::AccWidth-1:0]     acc_sat;
  logic [15:0]                       dim_val;
  logic [ppmh_pkg::CntWidth-1:0]     seen_inc;
  logic [ppmh_pkg::CntWidth-1:0]     expected_new;
  ppmh_pkg::result_t                 res;

  // Classify the byte
  always_comb begin
    is_ws    = (data_i inside {[ppmh_pkg::CharTab:ppmh_pkg::CharCr], ppmh_pkg::CharSpace});
    is_digit = (data_i inside {[ppmh_pkg::CharZero:ppmh_pkg::CharNine]});
    digit    = {16'd0, data_i - ppmh_pkg::CharZero};
  end

  // Decimal accumulate with saturation
  always_comb begin
    acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {4'd0, digit};
    acc_sat  = (acc_next > {4'd0, ppmh_pkg::AccMax}) ? ppmh_pkg::AccMax
                                                     : acc_next[ppmh_pkg::AccWidth-1:0];
  end

  // Held dimension, zero when out of range
  always_comb begin
    if (sign_q || acc_q == '0 || acc_q > MaxDim) begin
      dim_val = 16'd0;
    end else begin
      dim_val = acc_q[15:0];
    end
  end

  // Saturating pixel count and expected total
  always_comb begin
    seen_inc     = (seen_q == '1) ? seen_q : seen_q + 1'b1;
    expected_new = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
  end

  // Next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    first_ok_d = first_ok_q;
    sign_d     = sign_q;
    ended_d    = ended_q;
    acc_d      = acc_q;
    width_d    = width_q;
    height_d   = height_q;
    expected_d = expected_q;
    seen_d     = seen_q;
    res        = '0;

    if (step_en_i) begin
      case (phase_q)
        ppmh_pkg::PH_MAG0: begin
          if (eof_i) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrEarlyEnd;
          end else begin
            first_ok_d = (data_i == ppmh_pkg::CharP);
            phase_d    = ppmh_pkg::PH_MAG1;
          end
        end
        ppmh_pkg::PH_MAG1: begin
          if (eof_i) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrEarlyEnd;
          end else if (!(first_ok_q && data_i == ppmh_pkg::CharSix)) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrNotP6;
            phase_d = ppmh_pkg::PH_ERR;
          end else begin
            phase_d = ppmh_pkg::PH_SKIP_W;
          end
        end
        ppmh_pkg::PH_SKIP_W, ppmh_pkg::PH_SKIP_H, ppmh_pkg::PH_SKIP_M: begin
          if (data_i == ppmh_pkg::CharHash) begin
            if (eof_i) begin
              res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
              res.error_code = ppmh_pkg::ErrOpenComm;
            end else begin
              phase_d = ppmh_pkg::phase_e'(phase_q + 4'd1);
            end
          end else if (eof_i) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrEarlyEnd;
          end else if (!is_ws) begin
            // Open a token: sign, first digit or junk
            acc_d   = '0;
            sign_d  = 1'b0;
            ended_d = 1'b0;
            if (data_i == ppmh_pkg::CharPlus || data_i == ppmh_pkg::CharMinus) begin
              sign_d = (data_i == ppmh_pkg::CharMinus);
            end else if (is_digit) begin
              acc_d = digit;
            end else begin
              ended_d = 1'b1;
            end
            phase_d = ppmh_pkg::phase_e'(phase_q + 4'd2);
          end
        end
        ppmh_pkg::PH_COMM_W, ppmh_pkg::PH_COMM_H, ppmh_pkg::PH_COMM_M: begin
          if (data_i == ppmh_pkg::CharNewline) begin
            if (eof_i) begin
              res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
              res.error_code = ppmh_pkg::ErrEarlyEnd;
            end else begin
              phase_d = ppmh_pkg::phase_e'(phase_q - 4'd1);
            end
          end else if (eof_i) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrOpenComm;
          end
        end
        ppmh_pkg::PH_TOK_W, ppmh_pkg::PH_TOK_H, ppmh_pkg::PH_TOK_M: begin
          if (!is_ws) begin
            // Extend the token; digits stop at the first non-digit
            if (!ended_q && is_digit) begin
              acc_d = acc_sat;
            end else begin
              ended_d = 1'b1;
            end
            if (eof_i) begin
              res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
              res.error_code = ppmh_pkg::ErrEarlyEnd;
            end
          end else if (eof_i) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrEarlyEnd;
          end else if (phase_q == ppmh_pkg::PH_TOK_W) begin
            width_d = dim_val;
            phase_d = ppmh_pkg::PH_SKIP_H;
          end else if (phase_q == ppmh_pkg::PH_TOK_H) begin
            height_d = dim_val;
            phase_d  = ppmh_pkg::PH_SKIP_M;
          end else if (width_q == '0 || height_q == '0 ||
                       (!sign_q && acc_q > ppmh_pkg::MaxSample)) begin
            res.valid = 1'b1; res.kind = ppmh_pkg::KIND_ERROR;
            res.error_code = ppmh_pkg::ErrBadDims;
            phase_d = ppmh_pkg::PH_ERR;
          end else begin
            // Header complete: report it and arm the pixel count
            res.valid        = 1'b1;
            res.kind         = ppmh_pkg::KIND_HEADER;
            res.image_width  = width_q;
            res.image_height = height_q;
            res.max_value    = sign_q ? 25'(25'd0 - {1'b0, acc_q}) : {1'b0, acc_q};
            expected_d       = expected_new;
            seen_d           = '0;
            phase_d          = ppmh_pkg::PH_PIX;
          end
        end
        ppmh_pkg::PH_PIX: begin
          seen_d          = seen_inc;
          res.valid       = 1'b1;
          res.kind        = ppmh_pkg::KIND_PIXEL;
          res.pixel_value = data_i;
          if (eof_i) begin
            res.final_pixel   = 1'b1;
            res.size_mismatch = (seen_inc != expected_q);
          end
        end
        default: begin
          // Error phase: drop bytes until end of file
        end
      endcase

      // End of file returns everything to reset
      if (eof_i) begin
        phase_d    = ppmh_pkg::PH_MAG0;
        first_ok_d = 1'b0;
        sign_d     = 1'b0;
        ended_d    = 1'b0;
        acc_d      = '0;
        width_d    = '0;
        height_d   = '0;
        expected_d = '0;
        seen_d     = '0;
      end
    end
  end

  assign result_o = res;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ppmh_pkg::PH_MAG0;
      first_ok_q <= 1'b0;
      sign_q     <= 1'b0;
      ended_q    <= 1'b0;
      acc_q      <= '0;
      width_q    <= '0;
      height_q   <= '0;
      expected_q <= '0;
      seen_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      first_ok_q <= first_ok_d;
      sign_q     <= sign_d;
      ended_q    <= ended_d;
      acc_q      <= acc_d;
      width_q    <= width_d;
      height_q   <= height_d;
      expected_q <= expected_d;
      seen_q     <= seen_d;
    end
  end

  // Image area; settles well before the maxval delimiter arrives
  always_ff @(posedge clk_i) begin
    prod_q <= width_q * height_q;
  end

  a_result_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> step_en_i) else $error("result without an accepted byte");

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && eof_i |=> phase_q == ppmh_pkg::PH_MAG0 && seen_q == '0 && acc_q == '0)
    else $error("end of file did not return the parser to reset");

  a_pixel_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.kind == ppmh_pkg::KIND_PIXEL |-> phase_q == ppmh_pkg::PH_PIX)
    else $error("pixel result outside the pixel phase");

  a_header_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.kind == ppmh_pkg::KIND_HEADER
      |-> result_o.image_width != '0 && result_o.image_height != '0 &&
          expected_d != '0)
    else $error("header reported with an empty image");

endmodule

// ===== rtl/core/ppm_binary_header_parser.sv =====
// Top level of the binary PPM header parser: stream ports and result register.
//
//  channel  dir  tdata                                     tuser  tlast
//  s_axis   in   [7:0] data_byte                           -      end_of_file
//  m_axis   out  width, height, maxval, error, pixel, mis  kind   final_pixel
//
// One byte per cycle unless the output stalls: every accepted byte is parsed
// in the cycle it arrives and its result, if any, goes into the output register.
// A byte may be accepted while a result waits, as long as the result is
// taken in the same cycle. Reset clears the parser to expect the magic.
// Output stalls hold the input off through s_axis_tready; no byte is lost.
module ppm_binary_header_parser #(
  parameter logic [ppmh_pkg::AccWidth-1:0] MaxDim = ppmh_pkg::MaxDim
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] image_width, [31:16] image_height, [56:32] max_value,
  // [59:57] error_code, [67:60] pixel_value, [68] size_mismatch, [71:69] zero
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // final_pixel
);

  logic              in_fire;
  logic              out_valid_q;
  ppmh_pkg::result_t res;
  ppmh_pkg::result_t out_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ppmh_core #(
    .MaxDim (MaxDim)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (in_fire),
    .data_i    (s_axis_tdata),
    .eof_i     (s_axis_tlast),
    .result_o  (res)
  );

  // Result valid: set by a new result, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.final_pixel;
  assign m_axis_tdata  = {3'b000, out_q.size_mismatch, out_q.pixel_value, out_q.error_code,
                          out_q.max_value, out_q.image_height, out_q.image_width};

endmodule
